/* rtl/cbf_pkg.sv */
// Counting Bloom filter: shared constants, word types and control types.
// No dependencies; used by every module of the block but cbf_ram.
`default_nettype none

package cbf_pkg;

  localparam int unsigned NUM_COUNTERS   = 1024;
  localparam int unsigned NUM_HASHES     = 4;
  localparam int unsigned COUNTER_BITS   = 16;
  localparam int unsigned NUM_IDX_INPUTS = 4;
  localparam int unsigned NH_USED        =
      (NUM_HASHES < NUM_IDX_INPUTS) ? NUM_HASHES : NUM_IDX_INPUTS;

  localparam int unsigned ADDR_W   = $clog2(NUM_COUNTERS);
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SEL_W    = $clog2(NUM_IDX_INPUTS);
  localparam int unsigned SUM_W    =
      ((COUNTER_BITS > AMOUNT_W) ? COUNTER_BITS : AMOUNT_W) + 1;

  localparam logic [COUNTER_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_CONS  = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_QUERY = 3'd3,
    ACT_DEC   = 3'd4,
    ACT_CLEAR = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]          action;
    logic [INDEX_W-1:0]  index_0;
    logic [INDEX_W-1:0]  index_1;
    logic [INDEX_W-1:0]  index_2;
    logic [INDEX_W-1:0]  index_3;
    logic [AMOUNT_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ARD,
    ST_AWR,
    ST_MRD,
    ST_MCAP,
    ST_MCALC,
    ST_MWR,
    ST_DRD,
    ST_DWR,
    ST_CLR,
    ST_DONE
  } state_e;

  typedef enum logic {
    ASEL_HASH,
    ASEL_SWEEP
  } addr_sel_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_ADD,
    WR_DEC,
    WR_TARGET
  } wr_mode_e;

  typedef struct packed {
    logic      ram_re;
    logic      ram_we;
    addr_sel_e addr_sel;
    wr_mode_e  wr_mode;
    logic      latch_item;
    logic      hash_clr;
    logic      hash_inc;
    logic      sweep_inc;
    logic      add_step;
    logic      min_step;
    logic      calc_target;
    logic      load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    amount_zero;
    logic    hash_last;
    logic    sweep_last;
    logic    cons_sat;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* rtl/cbf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cbf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cbf_ctrl.sv */
// Counting Bloom filter controller: sequencing state machine and handshakes.
// Depends on cbf_pkg; drives cbf_dp through ctrl_cmd_t.
`default_nettype none

module cbf_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire cbf_pkg::ctrl_status_t status_i,
  output cbf_pkg::ctrl_cmd_t         cmd_o
);

  cbf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == cbf_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cbf_pkg::ST_INIT: begin
        if (status_i.sweep_last) state_d = cbf_pkg::ST_IDLE;
      end
      cbf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cbf_pkg::ST_DECODE;
      end
      cbf_pkg::ST_DECODE: begin
        case (status_i.action)
          cbf_pkg::ACT_ADD:   state_d = cbf_pkg::ST_ARD;
          cbf_pkg::ACT_CONS,
          cbf_pkg::ACT_FILL,
          cbf_pkg::ACT_QUERY: state_d = cbf_pkg::ST_MRD;
          cbf_pkg::ACT_DEC: begin
            state_d = status_i.amount_zero ? cbf_pkg::ST_DONE : cbf_pkg::ST_DRD;
          end
          cbf_pkg::ACT_CLEAR: state_d = cbf_pkg::ST_CLR;
          default:            state_d = cbf_pkg::ST_DONE;
        endcase
      end
      cbf_pkg::ST_ARD: state_d = cbf_pkg::ST_AWR;
      cbf_pkg::ST_AWR: begin
        state_d = status_i.hash_last ? cbf_pkg::ST_DONE : cbf_pkg::ST_ARD;
      end
      cbf_pkg::ST_MRD: state_d = cbf_pkg::ST_MCAP;
      cbf_pkg::ST_MCAP: begin
        if (!status_i.hash_last) begin
          state_d = cbf_pkg::ST_MRD;
        end else if (status_i.action == cbf_pkg::ACT_QUERY) begin
          state_d = cbf_pkg::ST_DONE;
        end else begin
          state_d = cbf_pkg::ST_MCALC;
        end
      end
      cbf_pkg::ST_MCALC: begin
        if (status_i.action == cbf_pkg::ACT_CONS && status_i.cons_sat) begin
          state_d = cbf_pkg::ST_DONE;
        end else begin
          state_d = cbf_pkg::ST_MWR;
        end
      end
      cbf_pkg::ST_MWR: begin
        if (status_i.hash_last) state_d = cbf_pkg::ST_DONE;
      end
      cbf_pkg::ST_DRD: state_d = cbf_pkg::ST_DWR;
      cbf_pkg::ST_DWR: begin
        state_d = status_i.sweep_last ? cbf_pkg::ST_DONE : cbf_pkg::ST_DRD;
      end
      cbf_pkg::ST_CLR: begin
        if (status_i.sweep_last) state_d = cbf_pkg::ST_DONE;
      end
      cbf_pkg::ST_DONE: begin
        if (out_free) state_d = cbf_pkg::ST_IDLE;
      end
      default: state_d = cbf_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = cbf_pkg::ASEL_HASH;
    cmd_o.wr_mode  = cbf_pkg::WR_ZERO;
    case (state_q)
      cbf_pkg::ST_INIT, cbf_pkg::ST_CLR: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.addr_sel  = cbf_pkg::ASEL_SWEEP;
        cmd_o.wr_mode   = cbf_pkg::WR_ZERO;
        cmd_o.sweep_inc = 1'b1;
      end
      cbf_pkg::ST_IDLE: begin
        cmd_o.latch_item = in_valid_i;
      end
      cbf_pkg::ST_ARD, cbf_pkg::ST_MRD: begin
        cmd_o.ram_re = 1'b1;
      end
      cbf_pkg::ST_AWR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.wr_mode  = cbf_pkg::WR_ADD;
        cmd_o.add_step = 1'b1;
        cmd_o.hash_inc = 1'b1;
      end
      cbf_pkg::ST_MCAP: begin
        cmd_o.min_step = 1'b1;
        cmd_o.hash_inc = 1'b1;
      end
      cbf_pkg::ST_MCALC: begin
        cmd_o.calc_target = 1'b1;
        cmd_o.hash_clr    = 1'b1;
      end
      cbf_pkg::ST_MWR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.wr_mode  = cbf_pkg::WR_TARGET;
        cmd_o.hash_inc = 1'b1;
      end
      cbf_pkg::ST_DRD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.addr_sel = cbf_pkg::ASEL_SWEEP;
      end
      cbf_pkg::ST_DWR: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.addr_sel  = cbf_pkg::ASEL_SWEEP;
        cmd_o.wr_mode   = cbf_pkg::WR_DEC;
        cmd_o.sweep_inc = 1'b1;
      end
      cbf_pkg::ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbf_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/cbf_dp.sv */
// Counting Bloom filter datapath: item and accumulator registers, counter
// arithmetic and counter-store addressing. Depends on cbf_pkg.
`default_nettype none

module cbf_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cbf_pkg::in_word_t                    in_data_i,
  input  wire cbf_pkg::ctrl_cmd_t                   cmd_i,
  output cbf_pkg::ctrl_status_t                     status_o,
  output logic                                      ram_we_o,
  output logic                                      ram_re_o,
  output logic [cbf_pkg::ADDR_W-1:0]                ram_addr_o,
  output logic [cbf_pkg::COUNTER_BITS-1:0]          ram_wdata_o,
  input  wire logic [cbf_pkg::COUNTER_BITS-1:0]     ram_rdata_i,
  output cbf_pkg::out_word_t                        out_data_o
);

  cbf_pkg::in_word_t                 item_q;
  cbf_pkg::out_word_t                out_q;
  cbf_pkg::action_e                  action;
  logic [cbf_pkg::SEL_W-1:0]         hash_q, hash_d;
  logic [cbf_pkg::ADDR_W-1:0]        sweep_q, sweep_d;
  logic [cbf_pkg::COUNTER_BITS-1:0]  vals_q [cbf_pkg::NUM_IDX_INPUTS];
  logic [cbf_pkg::COUNTER_BITS-1:0]  x_q, m_q, t_q;
  logic                              ovf_q;
  logic [cbf_pkg::ADDR_W-1:0]        idx_a [cbf_pkg::NUM_IDX_INPUTS];

  logic [cbf_pkg::SUM_W-1:0]         rd_ext, amt_ext, cmax_ext, add_sum, fill_sum;
  logic                              add_sat, fill_sat, tgt_cond, sweep_last;
  logic [cbf_pkg::COUNTER_BITS-1:0]  add_val, dec_val, res_count;

  assign action = cbf_pkg::action_e'(item_q.action);

  assign idx_a[0] = cbf_pkg::ADDR_W'(item_q.index_0);
  assign idx_a[1] = cbf_pkg::ADDR_W'(item_q.index_1);
  assign idx_a[2] = cbf_pkg::ADDR_W'(item_q.index_2);
  assign idx_a[3] = cbf_pkg::ADDR_W'(item_q.index_3);

  assign rd_ext   = cbf_pkg::SUM_W'(ram_rdata_i);
  assign amt_ext  = cbf_pkg::SUM_W'(item_q.amount);
  assign cmax_ext = cbf_pkg::SUM_W'(cbf_pkg::CMAX);

  assign add_sum  = rd_ext + amt_ext;
  assign add_sat  = add_sum > cmax_ext;
  assign add_val  = add_sat ? cbf_pkg::CMAX : add_sum[cbf_pkg::COUNTER_BITS-1:0];
  assign dec_val  = (rd_ext <= amt_ext) ? '0
                  : cbf_pkg::COUNTER_BITS'(rd_ext - amt_ext);
  assign fill_sum = cbf_pkg::SUM_W'(m_q) + amt_ext;
  assign fill_sat = fill_sum > cmax_ext;

  // conservative add raises counters at the minimum; fill raises those below
  assign tgt_cond = (action == cbf_pkg::ACT_CONS) ? (vals_q[hash_q] == m_q)
                                                  : (vals_q[hash_q] < t_q);

  assign sweep_last = (sweep_q == cbf_pkg::ADDR_W'(cbf_pkg::NUM_COUNTERS - 1));

  always_comb begin
    ram_re_o   = cmd_i.ram_re;
    ram_we_o   = cmd_i.ram_we && (cmd_i.wr_mode != cbf_pkg::WR_TARGET || tgt_cond);
    ram_addr_o = (cmd_i.addr_sel == cbf_pkg::ASEL_SWEEP) ? sweep_q : idx_a[hash_q];
    case (cmd_i.wr_mode)
      cbf_pkg::WR_ZERO:   ram_wdata_o = '0;
      cbf_pkg::WR_ADD:    ram_wdata_o = add_val;
      cbf_pkg::WR_DEC:    ram_wdata_o = dec_val;
      cbf_pkg::WR_TARGET: ram_wdata_o = t_q;
      default:            ram_wdata_o = '0;
    endcase
  end

  always_comb begin
    status_o.action      = action;
    status_o.amount_zero = (item_q.amount == '0);
    status_o.hash_last   = (hash_q == cbf_pkg::SEL_W'(cbf_pkg::NH_USED - 1));
    status_o.sweep_last  = sweep_last;
    status_o.cons_sat    = (m_q == cbf_pkg::CMAX);
  end

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.latch_item || cmd_i.hash_clr) begin
      hash_d = '0;
    end else if (cmd_i.hash_inc) begin
      hash_d = hash_q + 1'b1;
    end
    sweep_d = sweep_q;
    if (cmd_i.latch_item) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_inc) begin
      sweep_d = sweep_last ? '0 : sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      sweep_q <= '0;
    end else begin
      hash_q  <= hash_d;
      sweep_q <= sweep_d;
    end
  end

  always_comb begin
    case (action)
      cbf_pkg::ACT_ADD:   res_count = ovf_q ? cbf_pkg::CMAX : x_q;
      cbf_pkg::ACT_CONS,
      cbf_pkg::ACT_FILL:  res_count = t_q;
      cbf_pkg::ACT_QUERY: res_count = m_q;
      default:            res_count = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_data_i;
      x_q    <= cbf_pkg::CMAX;
      m_q    <= cbf_pkg::CMAX;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.add_step) begin
      if (add_sat) begin
        ovf_q <= 1'b1;
      end else if (add_val < x_q) begin
        x_q <= add_val;
      end
    end
    if (cmd_i.min_step) begin
      vals_q[hash_q] <= ram_rdata_i;
      if (ram_rdata_i < m_q) m_q <= ram_rdata_i;
    end
    if (cmd_i.calc_target) begin
      if (action == cbf_pkg::ACT_CONS) begin
        if (m_q == cbf_pkg::CMAX) begin
          ovf_q <= 1'b1;
          t_q   <= cbf_pkg::CMAX;
        end else begin
          t_q <= m_q + 1'b1;
        end
      end else if (fill_sat) begin
        ovf_q <= 1'b1;
        t_q   <= cbf_pkg::CMAX;
      end else begin
        t_q <= fill_sum[cbf_pkg::COUNTER_BITS-1:0];
      end
    end
    if (cmd_i.load_out) begin
      out_q.count    <= cbf_pkg::COUNT_W'(res_count);
      out_q.overflow <= ovf_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* rtl/counting_bloom_filter_engine.sv */
// Counting Bloom filter engine, top level: controller, datapath, counter store.
// Depends on cbf_pkg, cbf_ram, cbf_ctrl and cbf_dp.
`default_nettype none

// Works on one word at a time; every step goes through the single counter
// RAM, one access per cycle. After reset a clearing pass writes all 1024
// counters before the first word is taken. Per word: add reads and then
// writes each hashed counter in turn, query reads each one, conservative
// add and water fill read them all, work out a target and write it to the
// counters that qualify, a conservative add on an already saturated minimum
// writes nothing, decrement reads and writes all 1024 counters, clear zeroes
// all 1024, and unused actions and a decrement by zero touch no counter. The
// result waits in an output register; the next word is taken once it has been loaded.
module counting_bloom_filter_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cbf_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cbf_pkg::out_word_t      out_data_o
);

  cbf_pkg::ctrl_cmd_t               cmd;
  cbf_pkg::ctrl_status_t            status;
  logic                             ram_we, ram_re;
  logic [cbf_pkg::ADDR_W-1:0]       ram_addr;
  logic [cbf_pkg::COUNTER_BITS-1:0] ram_wdata, ram_rdata;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .out_data_o  (out_data_o)
  );

  cbf_ram #(
    .WIDTH (cbf_pkg::COUNTER_BITS),
    .DEPTH (cbf_pkg::NUM_COUNTERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // read and write share one address: never both in a cycle
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("counter store read and written in the same cycle");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in progress");

  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.count == cbf_pkg::COUNT_W'(cbf_pkg::CMAX))
    else $error("overflow reported without a saturated count");

endmodule

`default_nettype wire

/* tb/counting_bloom_filter_engine_tb.sv */
// Self-checking testbench for counting_bloom_filter_engine: directed words, then random
// bursts, checked against a scoreboard that keeps its own copy of the counter store.
// Depends on cbf_pkg and the RTL of the block only.
module counting_bloom_filter_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  localparam logic [2:0]  ACT_SPARE_LO   = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;
  localparam int unsigned RANDOM_WORDS   = 1400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned HOT_SLOTS      = 8;
  localparam int unsigned MAX_REPORTS    = 50;

  class filter_scoreboard;
    logic [COUNTER_BITS-1:0] counters [NUM_COUNTERS];
    out_word_t               expected_q [$];
    int unsigned             mismatches;
    int unsigned             results_seen;

    function new();
      foreach (counters[j]) counters[j] = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function logic [COUNTER_BITS-1:0] key_minimum(logic [ADDR_W-1:0] slot [NUM_IDX_INPUTS]);
      logic [COUNTER_BITS-1:0] low;
      low = CMAX;
      for (int i = 0; i < NH_USED; i++) begin
        if (counters[slot[i]] < low) low = counters[slot[i]];
      end
      return low;
    endfunction

    function out_word_t predict_result(in_word_t w);
      logic [ADDR_W-1:0]       slot [NUM_IDX_INPUTS];
      logic [SUM_W-1:0]        acc;
      logic [COUNTER_BITS-1:0] low;
      logic [COUNTER_BITS-1:0] target;
      logic                    sat;
      out_word_t               r;
      r   = '0;
      sat = 1'b0;
      slot[0] = ADDR_W'(w.index_0 % NUM_COUNTERS);
      slot[1] = ADDR_W'(w.index_1 % NUM_COUNTERS);
      slot[2] = ADDR_W'(w.index_2 % NUM_COUNTERS);
      slot[3] = ADDR_W'(w.index_3 % NUM_COUNTERS);
      case (w.action)
        ACT_ADD: begin
          low = CMAX;
          for (int i = 0; i < NH_USED; i++) begin
            acc = SUM_W'(counters[slot[i]]) + SUM_W'(w.amount);
            if (acc > SUM_W'(CMAX)) begin
              counters[slot[i]] = CMAX;
              sat = 1'b1;
            end else begin
              counters[slot[i]] = acc[COUNTER_BITS-1:0];
              if (acc[COUNTER_BITS-1:0] < low) low = acc[COUNTER_BITS-1:0];
            end
          end
          r.count = COUNT_W'(sat ? CMAX : low);
        end
        ACT_CONS: begin
          low = key_minimum(slot);
          if (low == CMAX) begin
            sat     = 1'b1;
            r.count = COUNT_W'(CMAX);
          end else begin
            // a repeated index already moved past the minimum, so it rises once
            for (int i = 0; i < NH_USED; i++) begin
              if (counters[slot[i]] == low) counters[slot[i]] = low + 1'b1;
            end
            r.count = COUNT_W'(low + 1'b1);
          end
        end
        ACT_FILL: begin
          low = key_minimum(slot);
          acc = SUM_W'(low) + SUM_W'(w.amount);
          if (acc > SUM_W'(CMAX)) begin
            target = CMAX;
            sat    = 1'b1;
          end else begin
            target = acc[COUNTER_BITS-1:0];
          end
          for (int i = 0; i < NH_USED; i++) begin
            if (counters[slot[i]] < target) counters[slot[i]] = target;
          end
          r.count = COUNT_W'(target);
        end
        ACT_QUERY: r.count = COUNT_W'(key_minimum(slot));
        ACT_DEC: begin
          if (w.amount != '0) begin
            foreach (counters[j]) begin
              if (SUM_W'(counters[j]) <= SUM_W'(w.amount)) counters[j] = '0;
              else counters[j] = counters[j] - COUNTER_BITS'(w.amount);
            end
          end
        end
        ACT_CLEAR: foreach (counters[j]) counters[j] = '0;
        default: ;
      endcase
      r.overflow = sat;
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_q.push_back(predict_result(w));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding (count=%0d ovf=%0b)",
                                  results_seen, got.count, got.overflow));
        return;
      end
      want = expected_q.pop_front();
      if (got.count !== want.count)
        report_mismatch($sformatf("result %0d count got %0d want %0d",
                                  results_seen, got.count, want.count));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("result %0d overflow got %0b want %0b",
                                  results_seen, got.overflow, want.overflow));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  filter_scoreboard sb;
  int unsigned      hot_idx [HOT_SLOTS];
  int unsigned      idle_cycles;
  int unsigned      rx_mode;
  int unsigned      rx_left;
  int unsigned      rx_phase;

  counting_bloom_filter_engine dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // word waits on in_ready_o sampled at the rising edge; caller sits on a falling edge
  task automatic send_word(input in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [2:0] act, input int unsigned i0, input int unsigned i1,
                             input int unsigned i2, input int unsigned i3,
                             input int unsigned amt);
    in_word_t w;
    w.action  = act;
    w.index_0 = INDEX_W'(i0);
    w.index_1 = INDEX_W'(i1);
    w.index_2 = INDEX_W'(i2);
    w.index_3 = INDEX_W'(i3);
    w.amount  = AMOUNT_W'(amt);
    send_word(w);
  endtask

  task automatic hold_off(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_index();
    if ($urandom_range(0, 1) == 0) return hot_idx[$urandom_range(0, HOT_SLOTS - 1)];
    return $urandom_range(0, (1 << INDEX_W) - 1);
  endfunction

  function automatic int unsigned pick_amount();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 15);
    if (roll < 60) return $urandom_range(16'h8000, 16'hFFFF);
    if (roll < 65) return 0;
    if (roll < 72) return 16'hFFFF;
    return $urandom_range(0, 16'hFFFF);
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned roll;
    roll = $urandom_range(0, 999);
    if (roll < 300)      w.action = ACT_ADD;
    else if (roll < 500) w.action = ACT_CONS;
    else if (roll < 650) w.action = ACT_FILL;
    else if (roll < 920) w.action = ACT_QUERY;
    else if (roll < 950) w.action = ACT_DEC;
    else if (roll < 975) w.action = ACT_CLEAR;
    else if (roll < 988) w.action = ACT_SPARE_LO;
    else                 w.action = ACT_SPARE_HI;
    w.index_0 = INDEX_W'(pick_index());
    w.index_1 = INDEX_W'(pick_index());
    w.index_2 = INDEX_W'(pick_index());
    w.index_3 = INDEX_W'(pick_index());
    w.amount  = AMOUNT_W'(pick_amount());
    // decrements mostly small so the store keeps some weight
    if (w.action == ACT_DEC && $urandom_range(0, 3) != 0)
      w.amount = AMOUNT_W'($urandom_range(0, 40));
    return w;
  endfunction

  // receiver: runs of always-ready, coin-flip, mostly stalled and a fixed cadence
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_mode     <= 0;
      rx_left     <= 0;
      rx_phase    <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        2:       out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (rx_phase % 5 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned burst_left;
    sb = new();
    foreach (hot_idx[k]) hot_idx[k] = $urandom_range(0, (1 << INDEX_W) - 1);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_fields(ACT_QUERY, 0, 1023, 512, 1, 0);
    send_fields(ACT_ADD, 0, 1023, 512, 1, 0);
    send_fields(ACT_ADD, 5, 5, 5, 5, 100);
    send_fields(ACT_CONS, 5, 6, 6, 7, 16'h5A5A);
    send_fields(ACT_FILL, 5, 6, 7, 8, 50);
    send_fields(ACT_FILL, 8, 9, 9, 10, 0);
    send_fields(ACT_ADD, 1023, 1023, 0, 0, 16'hFFFF);
    send_fields(ACT_QUERY, 1023, 1023, 1023, 1023, 0);
    send_fields(ACT_CONS, 1023, 1023, 1023, 1023, 0);
    send_fields(ACT_FILL, 1023, 0, 1023, 0, 1);
    send_fields(ACT_FILL, 20, 21, 22, 23, 16'hFFFF);
    send_fields(ACT_ADD, 20, 21, 22, 23, 1);
    send_fields(ACT_ADD, 300, 301, 302, 303, 16'hFFFE);
    send_fields(ACT_ADD, 300, 301, 302, 303, 1);
    send_fields(ACT_DEC, 0, 0, 0, 0, 0);
    send_fields(ACT_QUERY, 300, 301, 302, 303, 0);
    send_fields(ACT_DEC, 682, 341, 1023, 0, 1);
    send_fields(ACT_QUERY, 1023, 1023, 1023, 1023, 16'hFFFF);
    send_fields(ACT_DEC, 0, 0, 0, 0, 16'hFFFF);
    send_fields(ACT_QUERY, 5, 6, 7, 8, 0);
    send_fields(ACT_ADD, 40, 41, 42, 43, 16'h1234);
    send_fields(ACT_CLEAR, 40, 41, 42, 43, 16'h1234);
    send_fields(ACT_QUERY, 40, 41, 42, 43, 0);
    send_fields(ACT_SPARE_LO, 1023, 0, 682, 341, 16'hFFFF);
    send_fields(ACT_SPARE_HI, 341, 682, 0, 1023, 16'hAAAA);
    drain_results();
    @(negedge clk_i);

    burst_left = $urandom_range(1, 24);
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 300 == 299) begin
        drain_results();
        foreach (hot_idx[k]) hot_idx[k] = $urandom_range(0, (1 << INDEX_W) - 1);
        @(negedge clk_i);
      end
      send_word(random_word());
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    sb.check_leftover();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cbf_pkg.sv
rtl/cbf_ram.sv
rtl/cbf_ctrl.sv
rtl/cbf_dp.sv
rtl/counting_bloom_filter_engine.sv
tb/counting_bloom_filter_engine_tb.sv
